// File: hw/rtl/dia_pkg.sv
package dia_pkg;

	// Default number of dictionary entries.
	localparam int DICT_DEPTH_DEF = 256;

	// Width and reset value of the block size register.
	localparam int BSIZE_W = 17;
	localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST = 17'd4096;

	// Item modes.
	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Search token that walks down the row of cells, one cell per cycle.
	typedef struct packed {
		logic        valid;
		logic        mode;
		logic [63:0] key;
		logic [7:0]  rd;
		logic        hit;
		logic        is_new;
		logic [7:0]  idx;
		logic [63:0] data;
	} tok_t;

	// One finished result item.
	typedef struct packed {
		logic [7:0]  index;
		logic        is_new;
		logic        dict_full;
		logic        block_end;
		logic [63:0] entry_value;
		logic [8:0]  dict_size;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

endpackage

// File: hw/rtl/dia_cell.sv
module dia_cell #(
	parameter int POS   = 0,
	parameter int CNT_W = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dia_pkg::tok_t tok_in,
	input  logic [CNT_W-1:0] count,
	output dia_pkg::tok_t tok_out
);

	localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);
	localparam logic [7:0] POS8 = 8'(POS % 256);
	localparam bit RD_REACH = (POS < 256);

	logic [63:0]   entry_q;
	dia_pkg::tok_t tok_q;
	dia_pkg::tok_t tok_d;
	logic          occupied;
	logic          append;

	// An entry takes part only while it lies below the fill count.
	always_comb begin
		tok_d    = tok_in;
		occupied = (POS_C < count);
		append   = 1'b0;
		if (tok_in.valid && !tok_in.hit) begin
			if (tok_in.mode == dia_pkg::MODE_ADD) begin
				if (occupied && (entry_q == tok_in.key)) begin
					tok_d.hit = 1'b1;
					tok_d.idx = POS8;
				end else if (POS_C == count) begin
					// First free cell and no earlier match: store the value here.
					append       = 1'b1;
					tok_d.hit    = 1'b1;
					tok_d.is_new = 1'b1;
					tok_d.idx    = POS8;
				end
			end else if (RD_REACH && (tok_in.rd == POS8)) begin
				tok_d.hit = 1'b1;
				if (occupied) begin
					tok_d.data = entry_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (append) begin
			entry_q <= tok_in.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: hw/rtl/dictionary_index_assigner.sv
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  mode, value, read_index
// output   out        out_valid/out_stall  index, is_new, dict_full, block_end,
//                                          entry_value, dict_size
// config   in         cfg_wr_en            cfg_wr_data (block size)
//
// An item is not accepted until the previous one is through: the search
// token walks the row of DICT_DEPTH cells at one cell per cycle, then the result and the
// counters are committed. Only one item is in the row at a time.
// Reset clears the fill count, the block counter and all control state; the stored
// entries are not cleared, since only entries below the fill count are ever looked at.
// A result waiting under out_stall sits in the output register while the next item is
// accepted; if that next result finishes while the output is still stalled, it waits in a
// holding register and the input stays stalled.
module dictionary_index_assigner #(
	parameter int DICT_DEPTH = dia_pkg::DICT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [63:0] value,
	input  logic [7:0]  read_index,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  index,
	output logic        is_new,
	output logic        dict_full,
	output logic        block_end,
	output logic [63:0] entry_value,
	output logic [8:0]  dict_size,
	// Configuration.
	input  logic        cfg_wr_en,
	input  logic [dia_pkg::BSIZE_W-1:0] cfg_wr_data
);

	localparam int CNT_W = $clog2(DICT_DEPTH + 1);

	// Token chain: chain[0] feeds the first cell, chain[DICT_DEPTH] leaves the last one.
	dia_pkg::tok_t chain [DICT_DEPTH+1];
	dia_pkg::tok_t head;
	logic [DICT_DEPTH-1:0] chain_vld;

	dia_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [dia_pkg::BSIZE_W-1:0] fill_q, fill_d, fill_inc;
	logic [dia_pkg::BSIZE_W-1:0] bsize_q;
	logic             out_vld_q, out_vld_d;
	dia_pkg::res_t    out_q, hold_q, res;
	logic             accept;
	logic             out_free;
	logic             commit;
	logic             load_out;
	logic             load_hold;
	logic             from_hold;
	dia_pkg::tok_t    last;
	logic [CNT_W+8:0] size_ext;
	logic [CNT_W+7:0] rd_ext;
	logic [CNT_W+7:0] cnt_ext;

	assign in_stall = (state_q != dia_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_vld_q || !out_stall;

	// A fresh token enters the first cell in the cycle the item is accepted.
	always_comb begin
		head       = '0;
		head.valid = accept;
		head.mode  = mode;
		head.key   = value;
		head.rd    = read_index;
	end

	assign chain[0] = head;

	for (genvar g = 0; g < DICT_DEPTH; g++) begin : g_cell
		dia_cell #(
			.POS   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[g]),
			.count   (count_q),
			.tok_out (chain[g+1])
		);
		assign chain_vld[g] = chain[g+1].valid;
	end

	assign last = chain[DICT_DEPTH];

	// Result of the token leaving the last cell, and the counters after it.
	always_comb begin
		res      = '0;
		count_d  = count_q;
		fill_d   = fill_q;
		fill_inc = fill_q + 1'b1;
		rd_ext   = {{CNT_W{1'b0}}, last.rd};
		cnt_ext  = {8'b0, count_q};
		if (last.mode == dia_pkg::MODE_ADD) begin
			if (last.hit) begin
				// Every index handed out, old or new, counts toward the current block.
				res.index  = last.idx;
				res.is_new = last.is_new;
				count_d    = count_q + CNT_W'(last.is_new);
				if (fill_inc >= bsize_q) begin
					res.block_end = 1'b1;
					fill_d        = '0;
				end else begin
					fill_d = fill_inc;
				end
			end else begin
				// No match and no free cell: the dictionary is full.
				res.dict_full = 1'b1;
			end
		end else begin
			res.index       = last.rd;
			res.dict_full   = !(rd_ext < cnt_ext);
			res.entry_value = last.data;
		end
		size_ext      = {9'b0, count_d};
		res.dict_size = size_ext[8:0];
	end

	// Control: scan, then deliver into the output register or park in the holding one.
	always_comb begin
		state_d   = state_q;
		commit    = 1'b0;
		load_out  = 1'b0;
		load_hold = 1'b0;
		from_hold = 1'b0;
		case (state_q)
			dia_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = dia_pkg::ST_SCAN;
				end
			end
			dia_pkg::ST_SCAN: begin
				if (last.valid) begin
					commit = 1'b1;
					if (out_free) begin
						load_out = 1'b1;
						state_d  = dia_pkg::ST_IDLE;
					end else begin
						load_hold = 1'b1;
						state_d   = dia_pkg::ST_HOLD;
					end
				end
			end
			dia_pkg::ST_HOLD: begin
				if (out_free) begin
					load_out  = 1'b1;
					from_hold = 1'b1;
					state_d   = dia_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dia_pkg::ST_IDLE;
			end
		endcase
		if (load_out) begin
			out_vld_d = 1'b1;
		end else if (!out_stall) begin
			out_vld_d = 1'b0;
		end else begin
			out_vld_d = out_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dia_pkg::ST_IDLE;
			count_q   <= '0;
			fill_q    <= '0;
			bsize_q   <= dia_pkg::BLOCK_SIZE_RST;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_vld_q <= out_vld_d;
			if (commit) begin
				count_q <= count_d;
				fill_q  <= fill_d;
			end
			if (cfg_wr_en) begin
				bsize_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_hold) begin
			hold_q <= res;
		end
		if (load_out) begin
			out_q <= from_hold ? hold_q : res;
		end
	end

	assign out_valid   = out_vld_q;
	assign index       = out_q.index;
	assign is_new      = out_q.is_new;
	assign dict_full   = out_q.dict_full;
	assign block_end   = out_q.block_end;
	assign entry_value = out_q.entry_value;
	assign dict_size   = out_q.dict_size;

	// The fill count never runs past the number of cells.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DICT_DEPTH))
		else $error("entry count beyond dictionary depth");

	// At most one token is ever in the row of cells.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chain_vld))
		else $error("more than one token in the cell row");

	// A new item only enters an empty row.
	a_enter_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (chain_vld == '0))
		else $error("item accepted while a token is in flight");

	// A newly stored value gets the last index of the dictionary.
	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_new) |-> (!dict_full
			&& ({1'b0, index} == ((dict_size - 9'd1) & 9'h0FF))))
		else $error("new entry index does not match dictionary size");

endmodule
